// ===== rtl/bioimpedance_body_composition_defines.svh =====
// assertion helpers
`ifndef BIOIMPEDANCE_BODY_COMPOSITION_DEFINES_SVH
`define BIOIMPEDANCE_BODY_COMPOSITION_DEFINES_SVH

`ifndef ASSERT_OFF
`define BBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define BBC_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define BBC_ASSERT(lbl, prop)
`define BBC_ASSERT_NR(lbl, prop)
`endif

`endif

// ===== rtl/bbc_pkg.sv =====
package bbc_pkg;

  localparam int unsigned FREQ_W = 27;
  localparam logic [FREQ_W-1:0] FREQ_LOW_HZ  = 27'd50000;
  localparam logic [FREQ_W-1:0] FREQ_HIGH_HZ = 27'd100000;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_LOW   = 2'd1;
  localparam logic [1:0] KIND_HIGH  = 2'd2;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_L = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MALE   = 3'd7;

  localparam logic [16:0] RST_START  = 17'd50000;
  localparam logic [16:0] RST_STEP   = 17'd1000;
  localparam logic [31:0] RST_GAIN_L = 32'd884337;
  localparam logic [31:0] RST_GAIN_H = 32'd1462350;
  localparam logic [7:0]  RST_HEIGHT = 8'd183;
  localparam logic [7:0]  RST_WEIGHT = 8'd73;
  localparam logic [6:0]  RST_AGE    = 7'd22;
  localparam logic        RST_MALE   = 1'b1;

  localparam logic [41:0] Q_TBW_BASE    = 42'd438436;
  localparam logic [14:0] Q_HEIGHT_COEF = 15'd22658;
  localparam logic [41:0] Q_WEIGHT_COEF = 42'd11184;
  localparam logic [41:0] Q_AGE_COEF    = 42'd7209;
  localparam logic [41:0] Q_MALE_COEF   = 42'd174326;

  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [31:0] FFM_RECIP = 32'((64'd1 << RECIP_SHIFT) / 64'd73);

  localparam int unsigned SQRT_CELLS  = 24;
  localparam int unsigned DIV_CELLS   = 32;
  localparam int unsigned BODY_STAGES = 7;

  localparam logic [55:0] DIV_SAT_P = 56'd1 << 20;

  typedef struct packed {
    logic [1:0]  kind;
    logic        zero;
    logic [15:0] tbw;
    logic [15:0] ffm;
    logic [15:0] fm;
  } bbc_side_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [47:0] rad;
    logic [25:0] rem;
    logic [23:0] root;
  } bbc_sq_t;

  typedef struct packed {
    logic        valid;
    bbc_side_t   side;
    logic [55:0] p;
    logic [55:0] rem;
    logic [31:0] quo;
  } bbc_dv_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] imp;
    logic [15:0] tbw;
    logic [15:0] ffm;
    logic [15:0] fm;
    logic        zero;
  } bbc_res_t;

  function automatic logic [15:0] sat16(input logic [41:0] v);
    sat16 = (|v[41:24]) ? 16'hFFFF : v[23:8];
  endfunction

endpackage

// ===== rtl/bbc_sqrt_cell.sv =====
module bbc_sqrt_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  bbc_pkg::bbc_sq_t in_i,
  output bbc_pkg::bbc_sq_t out_o
);
  import bbc_pkg::*;

  logic [27:0] rs;
  logic [27:0] trial;
  logic        ge;
  bbc_sq_t     nxt;
  bbc_sq_t     cell_q;

  always_comb begin
    rs        = {in_i.rem, in_i.rad[47:46]};
    trial     = {2'b00, in_i.root, 2'b01};
    ge        = rs >= trial;
    nxt       = in_i;
    nxt.rem   = ge ? 26'(rs - trial) : 26'(rs);
    nxt.root  = {in_i.root[22:0], ge};
    nxt.rad   = {in_i.rad[45:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= nxt;
    end
  end

  assign out_o = cell_q;

endmodule

// ===== rtl/bbc_div_cell.sv =====
module bbc_div_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  bbc_pkg::bbc_dv_t in_i,
  output bbc_pkg::bbc_dv_t out_o
);
  import bbc_pkg::*;

  logic [56:0] rs;
  logic [56:0] dv;
  logic        ge;
  bbc_dv_t     nxt;
  bbc_dv_t     cell_q;

  always_comb begin
    rs      = {in_i.rem, 1'b0};
    dv      = {1'b0, in_i.p};
    ge      = rs >= dv;
    nxt     = in_i;
    nxt.rem = ge ? 56'(rs - dv) : 56'(rs);
    nxt.quo = {in_i.quo[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= nxt;
    end
  end

  assign out_o = cell_q;

endmodule

// ===== rtl/bbc_body.sv =====
module bbc_body (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  logic [1:0]          in_kind_i,
  input  logic [55:0]         in_p_i,
  input  logic [7:0]          height_i,
  input  logic [7:0]          weight_i,
  input  logic [6:0]          age_i,
  input  logic                male_i,
  output logic                out_valid_o,
  output bbc_pkg::bbc_side_t  out_side_o,
  output logic [55:0]         out_p_o
);
  import bbc_pkg::*;

  logic [BODY_STAGES-1:0] vld_q;
  logic [1:0]             kind_q [BODY_STAGES];
  logic [55:0]            p_q    [BODY_STAGES];

  logic [15:0] h2_q;
  logic [55:0] h2pz_q;
  logic [55:0] term_prod;
  logic [38:0] term_q;
  logic [41:0] tbw_q;
  logic [41:0] tabs;
  logic [31:0] x_q, x5_q;
  logic        neg4_q, neg5_q, neg6_q;
  logic        big4_q, big5_q, big6_q;
  logic [15:0] tbwo4_q, tbwo5_q, tbwo6_q;
  logic [63:0] recip_prod;
  logic [25:0] q0_q;
  logic [31:0] corr_r;
  logic [25:0] ffm_abs_q;
  logic [27:0] ffm_s;
  logic [27:0] fm_s;
  logic [27:0] fm_abs;
  bbc_side_t   side_d, side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[BODY_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    h2_q <= 16'(height_i) * 16'(height_i);
  end

  assign term_prod  = 56'(h2pz_q[55:16]) * 56'(Q_HEIGHT_COEF);
  assign tabs       = tbw_q[41] ? 42'(-tbw_q) : tbw_q;
  assign recip_prod = 64'(x_q) * 64'(FFM_RECIP);
  assign corr_r     = x5_q - 32'(q0_q) * 32'd73;

  always_comb begin
    ffm_s  = neg6_q ? 28'(-{2'b00, ffm_abs_q}) : {2'b00, ffm_abs_q};
    fm_s   = {4'b0000, weight_i, 16'h0000} - ffm_s;
    fm_abs = fm_s[27] ? 28'(-fm_s) : fm_s;
    side_d.kind = kind_q[BODY_STAGES-2];
    side_d.zero = (kind_q[BODY_STAGES-2] != KIND_OTHER) && (p_q[BODY_STAGES-2] == '0);
    side_d.tbw  = '0;
    side_d.ffm  = '0;
    side_d.fm   = '0;
    if (kind_q[BODY_STAGES-2] == KIND_HIGH) begin
      side_d.tbw = big6_q ? 16'hFFFF : tbwo6_q;
      side_d.ffm = big6_q ? 16'hFFFF : sat16(42'(ffm_abs_q));
      side_d.fm  = big6_q ? 16'hFFFF : sat16(42'(fm_abs));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q[0] <= in_kind_i;
      p_q[0]    <= in_p_i;
      for (int i = 1; i < BODY_STAGES; i++) begin
        kind_q[i] <= kind_q[i-1];
        p_q[i]    <= p_q[i-1];
      end
      // height squared over impedance
      h2pz_q  <= 56'(h2_q) * 56'(in_p_i[55:16]);
      term_q  <= term_prod[54:16];
      tbw_q   <= Q_TBW_BASE + 42'(term_q) + 42'(weight_i) * Q_WEIGHT_COEF
                 - 42'(age_i) * Q_AGE_COEF + (male_i ? Q_MALE_COEF : 42'd0);
      x_q     <= 32'(tabs[24:0]) * 32'd100;
      neg4_q  <= tbw_q[41];
      big4_q  <= |tabs[41:25];
      tbwo4_q <= sat16(tabs);
      // divide by 73 through the reciprocal
      q0_q    <= recip_prod[RECIP_SHIFT+25:RECIP_SHIFT];
      x5_q    <= x_q;
      neg5_q  <= neg4_q;
      big5_q  <= big4_q;
      tbwo5_q <= tbwo4_q;
      ffm_abs_q <= q0_q + ((corr_r >= 32'd73) ? 26'd1 : 26'd0);
      neg6_q  <= neg5_q;
      big6_q  <= big5_q;
      tbwo6_q <= tbwo5_q;
      side_q  <= side_d;
    end
  end

  assign out_valid_o = vld_q[BODY_STAGES-1];
  assign out_side_o  = side_q;
  assign out_p_o     = p_q[BODY_STAGES-1];

endmodule

// ===== rtl/bioimpedance_body_composition.sv =====
// One sweep point enters per clock while s_tready_o is high and passes an input stage, a
// chain of 24 square-root cells (one result bit each), the gain multiply, 7 body-composition
// stages, a chain of 32 divider cells (one quotient bit each) and the output register; one
// result word leaves per point, in order. A skid stage behind the output register lets one
// more point finish while a result waits; beyond that the whole chain holds. Point kind and
// the zero-magnitude flag travel in m_tuser_o; impedance in 1/16 ohm, body values in 1/256.
`include "bioimpedance_body_composition_defines.svh"

module bioimpedance_body_composition (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // real_part, imag_part, point_index, zero fill
  input  logic [47:0]                   s_tdata_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // impedance, body_water, fat_free_mass, fat_mass
  output logic [79:0]                   m_tdata_o,
  // point_kind, zero_magnitude
  output logic [2:0]                    m_tuser_o,
  input  logic                          cfg_we_i,
  input  logic [bbc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i
);
  import bbc_pkg::*;

  logic [16:0] start_q, step_q;
  logic [31:0] gain_l_q, gain_h_q;
  logic [7:0]  height_q, weight_q;
  logic [6:0]  age_q;
  logic        male_q;

  logic        en;
  logic        acc;
  logic [15:0] re_in, im_in;
  logic [8:0]  idx_in;
  logic [FREQ_W-1:0] freq;
  logic [1:0]  kind_in;

  logic        v1_q;
  logic [1:0]  kind1_q;
  logic [31:0] sqre_q, sqim_q;

  bbc_sq_t     sq [SQRT_CELLS+1];
  logic        vp_q;
  logic [1:0]  kindp_q;
  logic [55:0] p_q;
  logic [31:0] gain_sel;

  logic        body_valid;
  bbc_side_t   body_side;
  logic [55:0] body_p;
  bbc_dv_t     dv [DIV_CELLS+1];

  bbc_res_t    res;
  bbc_res_t    out_d, out_q, sk_d, sk_q;
  logic        ov_d, ov_q, skv_d, skv_q;
  logic        take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= RST_START;
      step_q   <= RST_STEP;
      gain_l_q <= RST_GAIN_L;
      gain_h_q <= RST_GAIN_H;
      height_q <= RST_HEIGHT;
      weight_q <= RST_WEIGHT;
      age_q    <= RST_AGE;
      male_q   <= RST_MALE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START:  start_q  <= cfg_data_i[16:0];
        CFG_STEP:   step_q   <= cfg_data_i[16:0];
        CFG_GAIN_L: gain_l_q <= cfg_data_i;
        CFG_GAIN_H: gain_h_q <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i[7:0];
        CFG_WEIGHT: weight_q <= cfg_data_i[7:0];
        CFG_AGE:    age_q    <= cfg_data_i[6:0];
        CFG_MALE:   male_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign en         = !skv_q;
  assign s_tready_o = en;
  assign acc        = s_tvalid_i && en;
  assign re_in      = s_tdata_i[15:0];
  assign im_in      = s_tdata_i[31:16];
  assign idx_in     = s_tdata_i[40:32];
  assign freq       = FREQ_W'(start_q) + FREQ_W'(idx_in) * FREQ_W'(step_q);

  always_comb begin
    if (freq == FREQ_LOW_HZ) begin
      kind_in = KIND_LOW;
    end else if (freq == FREQ_HIGH_HZ) begin
      kind_in = KIND_HIGH;
    end else begin
      kind_in = KIND_OTHER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vp_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc;
      vp_q <= sq[SQRT_CELLS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind1_q <= kind_in;
      sqre_q  <= 32'($signed(re_in) * $signed(re_in));
      sqim_q  <= 32'($signed(im_in) * $signed(im_in));
      kindp_q <= sq[SQRT_CELLS].kind;
      p_q     <= 56'(gain_sel) * 56'(sq[SQRT_CELLS].root);
    end
  end

  assign gain_sel = (sq[SQRT_CELLS].kind == KIND_LOW) ? gain_l_q : gain_h_q;

  always_comb begin
    sq[0].valid = v1_q;
    sq[0].kind  = kind1_q;
    sq[0].rad   = {sqre_q + sqim_q, 16'h0000};
    sq[0].rem   = '0;
    sq[0].root  = '0;
  end

  for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
    bbc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .in_i   (sq[g]),
      .out_o  (sq[g+1])
    );
  end

  bbc_body u_body (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (vp_q),
    .in_kind_i   (kindp_q),
    .in_p_i      (p_q),
    .height_i    (height_q),
    .weight_i    (weight_q),
    .age_i       (age_q),
    .male_i      (male_q),
    .out_valid_o (body_valid),
    .out_side_o  (body_side),
    .out_p_o     (body_p)
  );

  always_comb begin
    dv[0].valid = body_valid;
    dv[0].side  = body_side;
    dv[0].p     = body_p;
    dv[0].rem   = DIV_SAT_P;
    dv[0].quo   = '0;
  end

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    bbc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .in_i   (dv[g]),
      .out_o  (dv[g+1])
    );
  end

  always_comb begin
    res.kind = dv[DIV_CELLS].side.kind;
    res.tbw  = dv[DIV_CELLS].side.tbw;
    res.ffm  = dv[DIV_CELLS].side.ffm;
    res.fm   = dv[DIV_CELLS].side.fm;
    res.zero = dv[DIV_CELLS].side.zero;
    if (dv[DIV_CELLS].side.kind == KIND_OTHER) begin
      res.imp = '0;
    end else if (dv[DIV_CELLS].p <= DIV_SAT_P) begin
      res.imp = '1;
    end else begin
      res.imp = dv[DIV_CELLS].quo;
    end
  end

  assign take = !ov_q || m_tready_i;

  always_comb begin
    out_d = out_q;
    ov_d  = ov_q;
    sk_d  = sk_q;
    skv_d = skv_q;
    if (take) begin
      if (skv_q) begin
        out_d = sk_q;
        ov_d  = 1'b1;
        skv_d = 1'b0;
      end else begin
        out_d = res;
        ov_d  = dv[DIV_CELLS].valid;
      end
    end else if (en && dv[DIV_CELLS].valid) begin
      sk_d  = res;
      skv_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      skv_q <= 1'b0;
    end else begin
      ov_q  <= ov_d;
      skv_q <= skv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {out_q.fm, out_q.ffm, out_q.tbw, out_q.imp};
  assign m_tuser_o  = {out_q.zero, out_q.kind};

  `BBC_ASSERT_NR(a_skid_behind_out, skv_q |-> ov_q)
  `BBC_ASSERT(a_skid_fill_on_stall, $rose(skv_q) |-> $past(ov_q && !m_tready_i))
  `BBC_ASSERT(a_other_clear, ov_q && out_q.kind == KIND_OTHER |-> out_q.imp == '0 && !out_q.zero)
  `BBC_ASSERT(a_zero_sat, ov_q && out_q.zero |-> out_q.imp == '1)
  `BBC_ASSERT(a_low_no_body, ov_q && out_q.kind == KIND_LOW |-> out_q.tbw == '0 && out_q.fm == '0)

endmodule

// ===== verif/tb_bioimpedance_body_composition.sv =====
module tb_bioimpedance_body_composition;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int DRAIN_CYCLES = 90;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] imp;
    logic [15:0] tbw;
    logic [15:0] ffm;
    logic [15:0] fm;
    logic        zero;
  } point_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [47:0] s_tdata_i = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [79:0] m_tdata_o;
  logic [2:0]  m_tuser_o;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_START;
  logic [31:0] cfg_data_i = '0;

  bioimpedance_body_composition dut (.*);

  always #5 clk_i = ~clk_i;

  // register copy
  logic [16:0] start_hz, step_hz;
  logic [31:0] gain_lo, gain_hi;
  logic [7:0]  height, weight;
  logic [6:0]  age;
  logic        male;

  point_res_t expected_q[$];
  int errors = 0;
  int n_low = 0, n_high = 0, n_zero = 0, n_other = 0;
  bit send_burst = 0, recv_burst = 0, hold_req = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] body_out(input longint q16);
    longint unsigned m;
    m = (q16 < 0) ? longint'(-q16) : q16;
    m >>= 8;
    return (m > 64'hFFFF) ? 16'hFFFF : m[15:0];
  endfunction

  function automatic point_res_t eval_point(input logic signed [15:0] re,
                                            input logic signed [15:0] im,
                                            input logic [8:0] idx);
    point_res_t r;
    longint unsigned freq, msq, mag8, gain, p, q, h2z, term, tabs, ffm_mag;
    longint tbw, ffm, fm;
    longint sre, sim;
    r = '{KIND_OTHER, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0};
    freq = longint'(start_hz) + longint'(idx) * longint'(step_hz);
    if (freq == 50000 || freq == 100000) begin
      sre = re;
      sim = im;
      msq = sre * sre + sim * sim;
      mag8 = int_sqrt(msq << 16);
      gain = (freq == 50000) ? gain_lo : gain_hi;
      p = gain * mag8;
      r.kind = (freq == 50000) ? KIND_LOW : KIND_HIGH;
      if (p == 0) begin
        r.zero = 1'b1;
        r.imp = 32'hFFFFFFFF;
      end else begin
        q = (64'd1 << 52) / p;
        r.imp = (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
      end
      if (r.kind == KIND_HIGH) begin
        h2z = (longint'(height) * longint'(height) * (p >> 16)) >> 16;
        term = (h2z * longint'(Q_HEIGHT_COEF)) >> 16;
        tbw = longint'(Q_TBW_BASE) + longint'(term)
            + longint'(weight) * longint'(Q_WEIGHT_COEF)
            - longint'(age) * longint'(Q_AGE_COEF)
            + longint'(male) * longint'(Q_MALE_COEF);
        tabs = (tbw < 0) ? longint'(-tbw) : tbw;
        ffm_mag = tabs * 100 / 73;
        ffm = (tbw < 0) ? -longint'(ffm_mag) : longint'(ffm_mag);
        fm = (longint'(weight) << 16) - ffm;
        r.tbw = body_out(tbw);
        r.ffm = body_out(ffm);
        r.fm = body_out(fm);
      end
    end
    return r;
  endfunction

  // sender: one sweep point per call, valid kept high across back-to-back words
  task automatic send_point(input logic signed [15:0] re, input logic signed [15:0] im,
                            input logic [8:0] idx);
    int gap;
    bit rdy;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tdata_i = {7'd0, idx, im, re};
    s_tvalid_i = 1'b1;
    do begin
      rdy = s_tready_o;
      @(posedge clk_i);
      if (!rdy) @(negedge clk_i);
    end while (!rdy);
    expected_q.push_back(eval_point(re, im, idx));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_tvalid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_START:  start_hz = val[16:0];
      CFG_STEP:   step_hz = val[16:0];
      CFG_GAIN_L: gain_lo = val;
      CFG_GAIN_H: gain_hi = val;
      CFG_HEIGHT: height = val[7:0];
      CFG_WEIGHT: weight = val[7:0];
      CFG_AGE:    age = val[6:0];
      default:    male = val[0];
    endcase
  endtask

  // index that lands on the given frequency, or a random one
  function automatic logic [8:0] index_for(input longint unsigned f);
    longint unsigned d;
    if (step_hz == 0) return 9'($urandom_range(0, 511));
    if (f < start_hz) return 9'($urandom_range(0, 511));
    d = f - start_hz;
    if (d % step_hz != 0 || d / step_hz > 511) return 9'($urandom_range(0, 511));
    return 9'(d / step_hz);
  endfunction

  function automatic logic [15:0] rand_part();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 15) - 8);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random(input int n);
    logic [8:0] idx;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: idx = index_for(50000);
        4, 5, 6, 7: idx = index_for(100000);
        default: idx = 9'($urandom_range(0, 511));
      endcase
      send_point(rand_part(), rand_part(), idx);
    end
  endtask

  task automatic test_directed();
    send_point(16'sd0, 16'sd0, 9'd0);
    send_point(16'sd0, 16'sd0, 9'd50);
    send_point(16'sh7FFF, 16'sh7FFF, 9'd0);
    send_point(-16'sd32768, -16'sd32768, 9'd0);
    send_point(16'sh7FFF, -16'sd32768, 9'd50);
    send_point(-16'sd32768, 16'sh7FFF, 9'd50);
    send_point(16'sd1, 16'sd0, 9'd0);
    send_point(16'sd0, -16'sd1, 9'd50);
    send_point(16'sd1000, 16'sd200, 9'd0);
    send_point(-16'sd1200, 16'sd300, 9'd50);
    send_point(16'sd1234, 16'sd4321, 9'd511);
    send_point(16'sd77, 16'sd88, 9'd1);
    send_point(16'sd3, 16'sd4, 9'd49);
    send_point(16'shAAAA, 16'sh5555, 9'h155);
    send_point(16'sh5555, 16'shAAAA, 9'h0AA);
    drain();
  endtask

  task automatic test_zero_gain();
    write_reg(CFG_GAIN_L, 32'd0);
    write_reg(CFG_GAIN_H, 32'd0);
    send_point(16'sd500, 16'sd500, 9'd0);
    send_point(16'sd500, 16'sd500, 9'd50);
    send_random(30);
    drain();
  endtask

  task automatic test_config_extremes();
    // all points at 34464 Hz, so none at 50 or 100 kHz, heavy subject, masked writes
    write_reg(CFG_START, 32'hFFFE86A0);
    write_reg(CFG_STEP, 32'd0);
    write_reg(CFG_GAIN_L, 32'hFFFFFFFF);
    write_reg(CFG_GAIN_H, 32'hFFFFFFFF);
    write_reg(CFG_HEIGHT, 32'hFFFFFFFF);
    write_reg(CFG_WEIGHT, 32'd255);
    write_reg(CFG_AGE, 32'd127);
    write_reg(CFG_MALE, 32'd0);
    send_random(40);
    drain();
    write_reg(CFG_START, 32'd0);
    write_reg(CFG_STEP, 32'd100000);
    write_reg(CFG_HEIGHT, 32'd0);
    write_reg(CFG_WEIGHT, 32'd0);
    write_reg(CFG_AGE, 32'd0);
    write_reg(CFG_MALE, 32'd1);
    write_reg(CFG_GAIN_H, 32'd1);
    send_random(40);
    drain();
    write_reg(CFG_START, 32'h1FFFF);
    write_reg(CFG_STEP, 32'h1FFFF);
    send_random(20);
    drain();
  endtask

  task automatic test_random_phases();
    int steps[6] = '{1000, 500, 250, 100, 50, 10};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_STEP, steps[$urandom_range(0, 5)]);
      write_reg(CFG_START, 50000 - step_hz * $urandom_range(0, 30));
      write_reg(CFG_GAIN_L, $urandom_range(0, 1) ? $urandom() : $urandom_range(100000, 4000000));
      write_reg(CFG_GAIN_H, $urandom_range(0, 1) ? $urandom() : $urandom_range(100000, 4000000));
      write_reg(CFG_HEIGHT, $urandom());
      write_reg(CFG_WEIGHT, $urandom());
      write_reg(CFG_AGE, $urandom());
      write_reg(CFG_MALE, $urandom());
      send_burst = (ph == 2);
      recv_burst = (ph == 2 || ph == 4);
      send_random(210);
      send_burst = 0;
      recv_burst = 0;
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    send_burst = 1;
    send_random(150);
    send_burst = 0;
    drain();
  endtask

  // receiver
  initial begin
    int stall;
    bit vld;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_tready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 0;
      end
      stall = recv_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready_i = 1'b1;
      do begin
        vld = m_tvalid_o;
        @(posedge clk_i);
        if (!vld) @(negedge clk_i);
      end while (!vld);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    point_res_t e;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %0h/%0h",
                 $time, m_tuser_o, m_tdata_o);
      end else begin
        e = expected_q.pop_front();
        check_field("point_kind", e.kind, m_tuser_o[1:0]);
        check_field("zero_magnitude", e.zero, m_tuser_o[2]);
        check_field("impedance", e.imp, m_tdata_o[31:0]);
        check_field("body_water", e.tbw, m_tdata_o[47:32]);
        check_field("fat_free_mass", e.ffm, m_tdata_o[63:48]);
        check_field("fat_mass", e.fm, m_tdata_o[79:64]);
        case (e.kind)
          KIND_LOW:  n_low++;
          KIND_HIGH: n_high++;
          default:   n_other++;
        endcase
        if (e.zero) n_zero++;
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    start_hz = RST_START;
    step_hz = RST_STEP;
    gain_lo = RST_GAIN_L;
    gain_hi = RST_GAIN_H;
    height = RST_HEIGHT;
    weight = RST_WEIGHT;
    age = RST_AGE;
    male = RST_MALE;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_zero_gain();
    test_config_extremes();
    test_random_phases();
    test_backpressure();
    $display("points checked: %0d at 50 kHz, %0d at 100 kHz, %0d other, %0d zero magnitude",
             n_low, n_high, n_other, n_zero);
    $display("covered reset, extreme and random register settings plus a long output stall");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bbc_pkg.sv
rtl/bbc_sqrt_cell.sv
rtl/bbc_div_cell.sv
rtl/bbc_body.sv
rtl/bioimpedance_body_composition.sv
verif/tb_bioimpedance_body_composition.sv
